// File: rtl/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types and constants for the 3-D nearest neighbor distance sorter.
// ----------------------------------------------------------------------------
package knn_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned SqW    = 32;
  localparam int unsigned DistW  = 34;
  localparam int unsigned IdxW   = 6;

  localparam logic KindQuery = 1'b0;
  localparam logic KindPoint = 1'b1;

  // One request: a query point or a point of the set.
  typedef struct packed {
    logic                     kind;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic                     set_end;
  } req_t;

  // One result of a run.
  typedef struct packed {
    logic [IdxW-1:0]  point_index;
    logic [DistW-1:0] distance_sq;
    logic             run_end;
    logic             overflowed;
  } rsp_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  // One entry of the sorted memory.
  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [IdxW-1:0]  idx;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StDist,
    StCmp,
    StPlace,
    StEmit
  } state_e;

endpackage

// File: rtl/knn_mem.sv
// ----------------------------------------------------------------------------
// knn_mem
// Sorted entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module knn_mem
  import knn_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/knn_dist.sv
// ----------------------------------------------------------------------------
// knn_dist
// Squared distance unit: one axis squared per cycle, accumulated over three.
// ----------------------------------------------------------------------------
module knn_dist
  import knn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  point_t           point_i,
  input  point_t           query_i,
  output logic             done_o,
  output logic [DistW-1:0] dist_o
);

  localparam logic [1:0] StepX    = 2'd0;
  localparam logic [1:0] StepY    = 2'd1;
  localparam logic [1:0] StepZ    = 2'd2;
  localparam logic [1:0] StepLast = 2'd3;

  logic                     run_q, run_d;
  logic [1:0]               step_q, step_d;
  logic                     done_q, done_d;
  point_t                   pt_q, qry_q;
  logic [SqW-1:0]           sq_q;
  logic [DistW-1:0]         acc_q;
  logic signed [CoordW-1:0] a, b;
  logic signed [DiffW-1:0]  diff;
  logic signed [2*DiffW-1:0] prod;

  always_comb begin
    case (step_q)
      StepX: begin
        a = pt_q.x;
        b = qry_q.x;
      end
      StepY: begin
        a = pt_q.y;
        b = qry_q.y;
      end
      StepZ: begin
        a = pt_q.z;
        b = qry_q.z;
      end
      default: begin
        a = pt_q.z;
        b = qry_q.z;
      end
    endcase
    diff = DiffW'(a) - DiffW'(b);
    prod = diff * diff;
  end

  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = StepX;
    end else if (run_q) begin
      step_d = step_q + 2'd1;
      if (step_q == StepLast) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= StepX;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pt_q  <= point_i;
      qry_q <= query_i;
    end
    if (run_q) begin
      sq_q <= prod[SqW-1:0];
      if (step_q == StepX) begin
        acc_q <= '0;
      end else begin
        acc_q <= acc_q + DistW'(sq_q);
      end
    end
  end

  assign done_o = done_q;
  assign dist_o = acc_q;

endmodule

// File: rtl/knn_distance_sorter_top.sv
// ----------------------------------------------------------------------------
// knn_distance_sorter_top
// 3-D nearest neighbor sorter: keeps points ordered by squared distance.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// A request of kind query only replaces the stored query point and leaves
// busy low, so another request may follow in the next cycle. A request of
// kind point gets the next arrival index, and its squared distance to the
// query is formed by a shared 17x17 multiplier, one axis per cycle. The
// point is then inserted into a sorted memory by walking it from the top
// down: each stored entry that is strictly farther is read and written one
// place up, one entry per cycle through the single read port and the single
// write port. Points that arrive while the memory is full are dropped and
// flagged. On a point with set_end the stored points are read out nearest
// first, one result per cycle, each shown for one cycle with strobe_o high;
// the first one follows the final insert write through StEmit and the
// registered read port. The receiver cannot stall, so results are never
// held back. busy stays high until the last read of the run has been
// issued. Reset clears the query point, the point count and the overflow
// flag; the memory contents need no clearing.
// ----------------------------------------------------------------------------
module knn_distance_sorter_top
  import knn_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic strobe_o,
  output rsp_t result_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            last_q, last_d;
  logic [AW-1:0]   pos_q, pos_d;
  logic [AW-1:0]   k_q, k_d;
  point_t          query_q;
  point_t          point_in;

  logic            strobe_q, strobe_d;
  logic            run_end_q, run_end_d;
  logic            ovf_out_q, ovf_out_d;

  logic            accept;
  logic            dist_start;
  logic            dist_done;
  logic [DistW-1:0] pt_dist;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  entry_t          mem_rdata;
  entry_t          new_entry;

  assign accept   = start && !busy;
  assign busy     = (state_q != StIdle);
  assign point_in = '{x: req_i.coord_x, y: req_i.coord_y, z: req_i.coord_z};

  // The arrival index of the point being inserted equals the count so far.
  assign new_entry = '{distance: pt_dist, idx: IdxW'(count_q)};

  knn_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_start),
    .point_i (point_in),
    .query_i (query_q),
    .done_o  (dist_done),
    .dist_o  (pt_dist)
  );

  knn_mem #(
    .Depth (MAX_POINTS),
    .AddrW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    last_d     = last_q;
    pos_d      = pos_q;
    k_d        = k_q;
    dist_start = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = pos_q;
    mem_wdata  = new_entry;
    mem_re     = 1'b0;
    mem_raddr  = pos_q - AW'(1);
    strobe_d   = 1'b0;
    run_end_d  = 1'b0;
    ovf_out_d  = ovf_q;

    case (state_q)
      StIdle: begin
        if (accept && (req_i.kind == KindPoint)) begin
          last_d = req_i.set_end;
          if (count_q < CW'(MAX_POINTS)) begin
            dist_start = 1'b1;
            state_d    = StDist;
          end else begin
            // Memory is full: the point is dropped, but set_end still counts.
            ovf_d = 1'b1;
            if (req_i.set_end) begin
              k_d     = '0;
              state_d = StEmit;
            end
          end
        end
      end

      StDist: begin
        if (dist_done) begin
          pos_d = AW'(count_q);
          if (count_q == '0) begin
            state_d = StPlace;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(count_q - CW'(1));
            state_d   = StCmp;
          end
        end
      end

      StCmp: begin
        // The entry just below pos_q is on the read port. Entries that are
        // strictly farther move up one place; a tie keeps the older point first.
        if (mem_rdata.distance > pt_dist) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = mem_rdata;
          pos_d     = pos_q - AW'(1);
          if (pos_q == AW'(1)) begin
            state_d = StPlace;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pos_q - AW'(2);
          end
        end else begin
          mem_we  = 1'b1;
          count_d = count_q + CW'(1);
          k_d     = '0;
          state_d = last_q ? StEmit : StIdle;
        end
      end

      StPlace: begin
        mem_we  = 1'b1;
        count_d = count_q + CW'(1);
        k_d     = '0;
        state_d = last_q ? StEmit : StIdle;
      end

      StEmit: begin
        // One read per cycle; the result shows on the ports in the next cycle.
        mem_re    = 1'b1;
        mem_raddr = k_q;
        strobe_d  = 1'b1;
        if (CW'(k_q) == count_q - CW'(1)) begin
          run_end_d = 1'b1;
          count_d   = '0;
          ovf_d     = 1'b0;
          state_d   = StIdle;
        end else begin
          k_d = k_q + AW'(1);
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      last_q    <= 1'b0;
      pos_q     <= '0;
      k_q       <= '0;
      query_q   <= '0;
      strobe_q  <= 1'b0;
      run_end_q <= 1'b0;
      ovf_out_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      last_q    <= last_d;
      pos_q     <= pos_d;
      k_q       <= k_d;
      strobe_q  <= strobe_d;
      run_end_q <= run_end_d;
      ovf_out_q <= ovf_out_d;
      if (accept && (req_i.kind == KindQuery)) begin
        query_q <= point_in;
      end
    end
  end

  assign strobe_o = strobe_q;
  assign result_o = '{point_index: mem_rdata.idx,
                      distance_sq: mem_rdata.distance,
                      run_end:     run_end_q,
                      overflowed:  ovf_out_q};

endmodule
